/* rtl/tmr_pkg.sv */
// ----------------------------------------------------------------------------
// tmr_pkg
// Shared sizes, codes and types of the timer slot table.
// ----------------------------------------------------------------------------
package tmr_pkg;

    // table size and per-item result limit
    localparam int SLOTS       = 16;
    localparam int MAX_RESULTS = 16;

    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int RES_W  = $clog2(MAX_RESULTS + 1);
    localparam int QIDX_W = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

    localparam int TAG_W    = 8;
    localparam int PERIOD_W = 32;

    // item kinds
    localparam logic [1:0] KIND_REG   = 2'd0;
    localparam logic [1:0] KIND_UNREG = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_PARAM = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // one table entry as stored in the slot RAM
    typedef struct packed {
        logic [TAG_W-1:0]    tag;
        logic [PERIOD_W-1:0] remaining;
        logic [PERIOD_W-1:0] reload;
        logic                one_shot;
    } t_slot;

    // one queued result (last is derived at the output)
    typedef struct packed {
        logic [1:0]       status;
        logic             fired;
        logic [TAG_W-1:0] fired_tag;
    } t_res;

    // controller to datapath
    typedef struct packed {
        logic             load;
        logic             single;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             walk_end;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic [CNT_W-1:0] used;
        logic             drained;
    } t_dp_stat;

endpackage

/* rtl/tmr_if.sv */
// ----------------------------------------------------------------------------
// tmr_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface tmr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  tag;
    logic [31:0] period;
    logic        mode;

    modport source (output valid, kind, tag, period, mode, input ready);
    modport sink   (input valid, kind, tag, period, mode, output ready);
endinterface

interface tmr_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       fired;
    logic [7:0] fired_tag;
    logic       last;

    modport source (output valid, status, fired, fired_tag, last, input ready);
    modport sink   (input valid, status, fired, fired_tag, last, output ready);
endinterface

/* rtl/tmr_ram.sv */
// ----------------------------------------------------------------------------
// tmr_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tmr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

/* rtl/tmr_ctrl.sv */
// ----------------------------------------------------------------------------
// tmr_ctrl
// Sequencer: accepts an item, streams slot reads for a table walk when the
// item needs one, then waits until every result beat has left the block.
// ----------------------------------------------------------------------------
module tmr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [1:0]         i_in_kind,
    input  logic [7:0]         i_in_tag,
    output logic               o_in_ready,
    input  tmr_pkg::t_dp_stat  i_stat,
    output tmr_pkg::t_ctrl_cmd o_cmd
);
    import tmr_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WALK  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_n, n_n;
    logic             walk_item;

    // tick and a valid unregister need a pass over the table
    assign walk_item = (i_in_kind == KIND_TICK) ||
                       ((i_in_kind == KIND_UNREG) && (i_in_tag != '0));

    // next state and commands
    always_comb begin
        n_state       = r_state;
        n_rd          = r_rd;
        n_n           = r_n;
        o_in_ready    = 1'b0;
        o_cmd         = '0;
        o_cmd.rd_addr = r_rd[IDX_W-1:0];
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load   = 1'b1;
                    o_cmd.single = !walk_item;
                    n_rd         = '0;
                    n_n          = i_stat.used;
                    n_state      = walk_item ? S_WALK : S_DRAIN;
                end
            end
            S_WALK: begin
                if (r_rd != r_n) begin
                    o_cmd.rd_en = 1'b1;
                    n_rd        = r_rd + 1'b1;
                end else begin
                    // last read data is processed in this cycle
                    o_cmd.walk_end = 1'b1;
                    n_state        = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_stat.drained) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rd    <= '0;
            r_n     <= '0;
        end else begin
            r_state <= n_state;
            r_rd    <= n_rd;
            r_n     <= n_n;
        end
    end

endmodule

/* rtl/tmr_dp.sv */
// ----------------------------------------------------------------------------
// tmr_dp
// Datapath: slot RAM, compacting walk stage, occupancy count and the result
// queue that feeds the output channel.
// ----------------------------------------------------------------------------
module tmr_dp (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  tmr_pkg::t_ctrl_cmd     i_cmd,
    output tmr_pkg::t_dp_stat      o_stat,
    input  logic [1:0]             i_kind,
    input  logic [7:0]             i_tag,
    input  logic [31:0]            i_period,
    input  logic                   i_mode,
    tmr_out_if.source              o_out
);
    import tmr_pkg::*;

    // item context
    logic [1:0]       r_kind;
    logic [TAG_W-1:0] r_tag;
    logic [CNT_W-1:0] r_used, n_used;
    logic [CNT_W-1:0] r_wr,   n_wr;
    logic             r_found, n_found;
    logic [RES_W-1:0] r_nres, n_nres;
    logic             r_fin,  n_fin;
    logic             r_s1_vld;

    // result queue
    t_res              r_q [MAX_RESULTS];
    logic [QIDX_W-1:0] r_q_head, r_q_tail;
    logic [RES_W-1:0]  r_q_cnt;

    // RAM ports
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    t_slot             ram_wdata;
    logic [$bits(t_slot)-1:0] ram_rdata;

    t_slot            slot, upd;
    logic             is_tick, expired, drop, keep;
    logic [1:0]       single_st;
    logic             append;
    logic             push_fire, push, pop;
    t_res             push_data;

    tmr_ram #(
        .WIDTH ($bits(t_slot)),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_cmd.rd_addr),
        .o_rdata (ram_rdata)
    );

    // status of a one-beat item (register, bad unregister, unknown kind)
    always_comb begin
        single_st = ST_PARAM;
        append    = 1'b0;
        if (i_kind == KIND_REG) begin
            if ((i_tag == '0) || (i_period == '0)) begin
                single_st = ST_PARAM;
            end else if (r_used >= CNT_W'(SLOTS)) begin
                single_st = ST_FULL;
            end else begin
                single_st = ST_OK;
                append    = 1'b1;
            end
        end
    end

    // walk stage: decide per slot whether it stays and what it becomes
    assign slot    = t_slot'(ram_rdata);
    assign is_tick = (r_kind == KIND_TICK);
    assign expired = (slot.remaining == '0);

    always_comb begin
        upd  = slot;
        drop = 1'b0;
        if (is_tick) begin
            drop          = expired && slot.one_shot;
            upd.remaining = expired ? (slot.reload - 1'b1) : (slot.remaining - 1'b1);
        end else begin
            drop = !r_found && (slot.tag == r_tag);
        end
    end

    assign keep      = r_s1_vld && !drop;
    assign push_fire = r_s1_vld && is_tick && expired && (r_nres < RES_W'(MAX_RESULTS));

    // RAM write: append on register, compacted write-back during a walk
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_wr[IDX_W-1:0];
        ram_wdata = upd;
        if (i_cmd.single && append) begin
            ram_we              = 1'b1;
            ram_waddr           = r_used[IDX_W-1:0];
            ram_wdata.tag       = i_tag;
            ram_wdata.remaining = i_period;
            ram_wdata.reload    = i_period;
            ram_wdata.one_shot  = i_mode;
        end else if (keep) begin
            ram_we = 1'b1;
        end
    end

    // result selection into the queue
    always_comb begin
        push      = 1'b0;
        push_data = '0;
        if (i_cmd.single) begin
            push             = 1'b1;
            push_data.status = single_st;
        end else if (push_fire) begin
            push                = 1'b1;
            push_data.status    = ST_OK;
            push_data.fired     = 1'b1;
            push_data.fired_tag = slot.tag;
        end else if (i_cmd.walk_end && (!is_tick || (r_nres == '0))) begin
            push             = 1'b1;
            push_data.status = ST_OK;
        end
    end

    // context next values
    always_comb begin
        n_used  = r_used;
        n_wr    = r_wr;
        n_found = r_found;
        n_nres  = r_nres;
        n_fin   = r_fin;
        if (i_cmd.load) begin
            n_wr    = '0;
            n_found = 1'b0;
            n_nres  = '0;
            n_fin   = i_cmd.single;
            if (i_cmd.single && append) begin
                n_used = r_used + 1'b1;
            end
        end else begin
            if (r_s1_vld && drop) begin
                n_used = r_used - 1'b1;
                if (!is_tick) begin
                    n_found = 1'b1;
                end
            end
            if (keep) begin
                n_wr = r_wr + 1'b1;
            end
            if (push) begin
                n_nres = r_nres + 1'b1;
            end
            if (i_cmd.walk_end) begin
                n_fin = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_wr     <= '0;
            r_found  <= 1'b0;
            r_nres   <= '0;
            r_fin    <= 1'b1;
            r_s1_vld <= 1'b0;
            r_q_head <= '0;
            r_q_tail <= '0;
            r_q_cnt  <= '0;
        end else begin
            r_used   <= n_used;
            r_wr     <= n_wr;
            r_found  <= n_found;
            r_nres   <= n_nres;
            r_fin    <= n_fin;
            r_s1_vld <= i_cmd.rd_en;
            if (push) begin
                r_q_tail <= r_q_tail + 1'b1;
            end
            if (pop) begin
                r_q_head <= r_q_head + 1'b1;
            end
            r_q_cnt <= r_q_cnt + RES_W'(push) - RES_W'(pop);
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_tag  <= i_tag;
        end
        if (push) begin
            r_q[r_q_tail] <= push_data;
        end
    end

    // output: hold back the newest beat until the walk is over, so that
    // the final beat of an item can carry last
    assign o_out.valid     = (r_q_cnt >= RES_W'(2)) || (r_fin && (r_q_cnt != '0));
    assign o_out.status    = r_q[r_q_head].status;
    assign o_out.fired     = r_q[r_q_head].fired;
    assign o_out.fired_tag = r_q[r_q_head].fired_tag;
    assign o_out.last      = r_fin && (r_q_cnt == RES_W'(1));
    assign pop             = o_out.valid && o_out.ready;

    assign o_stat.used    = r_used;
    assign o_stat.drained = r_fin && (r_q_cnt == '0);

`ifndef ASSERT_OFF
    // occupancy stays within the table
    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(SLOTS))
        else $error("slot count above table size");

    // the result queue never overflows
    a_q_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |-> (r_q_cnt < RES_W'(MAX_RESULTS)))
        else $error("result queue overflow");

    // compacted write-back stays inside the occupied part of the table
    a_wr_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        keep |-> (r_wr < r_used))
        else $error("walk write beyond used slots");

    // a finished walk leaves at least one beat for the item
    a_walk_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.walk_end |=> (r_q_cnt != '0) || $past(pop))
        else $error("walk ended without a result");
`endif

endmodule

/* rtl/multi_slot_software_timer_table_top.sv */
// ----------------------------------------------------------------------------
// multi_slot_software_timer_table_top
// Packed table of timer slots with register, unregister and tick commands.
//
//  channel  | dir | beat contents
//  ---------+-----+--------------------------------------------
//  i_in     | in  | kind, tag, period, mode
//  o_out    | out | status, fired, fired_tag, last
//
// Register, unregister with tag 0 and unknown kinds: the result beat is ready
// in the cycle after the command is taken, and the block is free again once
// that beat is taken and the sequencer has seen the emptied queue. Unregister
// and tick stream one slot per cycle out of the slot RAM, then the result
// queue drains; the drain overlaps the walk except for the final beat.
// Reset (synchronous, active low) empties the table; no clearing pass.
// Output stalls never stall the walk: up to 16 beats wait in a queue.
// ----------------------------------------------------------------------------
module multi_slot_software_timer_table_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tmr_in_if.sink     i_in,
    tmr_out_if.source  o_out
);
    import tmr_pkg::*;

    t_ctrl_cmd cmd;
    t_dp_stat  stat;

    tmr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_kind  (i_in.kind),
        .i_in_tag   (i_in.tag),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tmr_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .i_kind   (i_in.kind),
        .i_tag    (i_in.tag),
        .i_period (i_in.period),
        .i_mode   (i_in.mode),
        .o_out    (o_out)
    );

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the timer slot table. Commands go in over the
// command channel and are mirrored in a behavioral copy of the table, which
// queues the result beats each command should produce. Every beat that
// leaves the block is compared field by field with the oldest queued beat.
// A short directed part covers rejected commands, a full table and a tick
// that expires a whole chain of one-shot slots. A random part then mixes
// register bursts, unregisters and ticks under several idle and stall mixes.
// ----------------------------------------------------------------------------
module testbench;
    import tmr_pkg::*;

    // kind code with no meaning in the block
    localparam logic [1:0] KIND_UNDEF = 2'd3;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = SLOTS + 4;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [1:0]       status;
        logic             fired;
        logic [TAG_W-1:0] fired_tag;
        logic             last;
    } t_beat;

    logic i_clk;
    logic i_rst_n;

    tmr_in_if  cmd_ch ();
    tmr_out_if res_ch ();

    multi_slot_software_timer_table_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_out   (res_ch)
    );

    // mirror of the slot table and the beats it still owes
    t_slot tbl [SLOTS];
    int    tbl_used;
    t_beat due_beats [$];

    int send_idle_pct;
    int recv_stall_pct;
    int n_items;
    int n_beats;
    int n_fired;
    int n_full;
    int n_errors;
    int idle_cycles;

    // ------------------------------------------------------------------------
    // Table mirror
    // ------------------------------------------------------------------------
    function automatic void push_beat(logic [1:0] st, logic fired, logic [TAG_W-1:0] tag,
                                      logic last);
        t_beat b;
        b.status    = st;
        b.fired     = fired;
        b.fired_tag = tag;
        b.last      = last;
        due_beats.push_back(b);
    endfunction

    // remove one slot, later slots move down one place
    function automatic void drop_slot(int idx);
        for (int j = idx; j + 1 < tbl_used; j++) begin
            tbl[j] = tbl[j + 1];
        end
        tbl_used--;
    endfunction

    function automatic void predict_item(logic [1:0] kind, logic [TAG_W-1:0] tag,
                                         logic [PERIOD_W-1:0] period, logic mode);
        t_beat held;
        bit    have_held;
        int    i;
        int    n;
        case (kind)
            KIND_REG: begin
                if (tag == 0 || period == 0) begin
                    push_beat(ST_PARAM, 1'b0, '0, 1'b1);
                end else if (tbl_used >= SLOTS) begin
                    push_beat(ST_FULL, 1'b0, '0, 1'b1);
                end else begin
                    tbl[tbl_used].tag       = tag;
                    tbl[tbl_used].remaining = period;
                    tbl[tbl_used].reload    = period;
                    tbl[tbl_used].one_shot  = mode;
                    tbl_used++;
                    push_beat(ST_OK, 1'b0, '0, 1'b1);
                end
            end
            KIND_UNREG: begin
                if (tag == 0) begin
                    push_beat(ST_PARAM, 1'b0, '0, 1'b1);
                end else begin
                    // first match only; unknown tag is still a success
                    for (i = 0; i < tbl_used; i++) begin
                        if (tbl[i].tag == tag) begin
                            drop_slot(i);
                            break;
                        end
                    end
                    push_beat(ST_OK, 1'b0, '0, 1'b1);
                end
            end
            KIND_TICK: begin
                // hold back one firing so the final one can carry last
                n = 0;
                i = 0;
                have_held = 1'b0;
                while (i < tbl_used) begin
                    if (tbl[i].remaining == 0) begin
                        if (n < MAX_RESULTS) begin
                            if (have_held) due_beats.push_back(held);
                            held.status    = ST_OK;
                            held.fired     = 1'b1;
                            held.fired_tag = tbl[i].tag;
                            held.last      = 1'b0;
                            have_held      = 1'b1;
                            n++;
                        end
                        // one-shot leaves; the slot shifted in is examined now
                        if (tbl[i].one_shot) begin
                            drop_slot(i);
                            continue;
                        end
                        tbl[i].remaining = tbl[i].reload;
                    end
                    tbl[i].remaining = tbl[i].remaining - 1;
                    i++;
                end
                if (have_held) begin
                    held.last = 1'b1;
                    due_beats.push_back(held);
                end else begin
                    push_beat(ST_OK, 1'b0, '0, 1'b1);
                end
            end
            default: begin
                push_beat(ST_PARAM, 1'b0, '0, 1'b1);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Result side: random stalls
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_beat want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            n_beats++;
            if (res_ch.fired) n_fired++;
            if (res_ch.status == ST_FULL) n_full++;
            if (due_beats.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("unexpected beat: status %0d fired %0b tag %0d last %0b",
                             res_ch.status, res_ch.fired, res_ch.fired_tag, res_ch.last);
            end else begin
                want = due_beats.pop_front();
                if (res_ch.status !== want.status || res_ch.fired !== want.fired ||
                    res_ch.fired_tag !== want.fired_tag || res_ch.last !== want.last) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS) begin
                        $display("mismatch at beat %0d: expected status %0d fired %0b tag %0d last %0b",
                                 n_beats, want.status, want.fired, want.fired_tag, want.last);
                        $display("  got status %0d fired %0b tag %0d last %0b",
                                 res_ch.status, res_ch.fired, res_ch.fired_tag, res_ch.last);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: cycles with no beat on either channel
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat moved in %0d cycles", WATCHDOG_LIMIT);
            $display("testbench: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [1:0] kind, input logic [TAG_W-1:0] tag,
                             input logic [PERIOD_W-1:0] period, input logic mode);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid  <= 1'b1;
        cmd_ch.kind   <= kind;
        cmd_ch.tag    <= tag;
        cmd_ch.period <= period;
        cmd_ch.mode   <= mode;
        do @(posedge i_clk); while (cmd_ch.ready !== 1'b1);
        n_items++;
        predict_item(kind, tag, period, mode);
    endtask

    // hold commands until every owed beat is back and the walk has settled
    task automatic wait_for_results();
        cmd_ch.valid <= 1'b0;
        while (due_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // rejected and no-op commands on an empty table
    task automatic test_rejects();
        send_item(KIND_UNDEF, 8'hA5, 32'h5A5A_5A5A, 1'b1);
        send_item(KIND_REG, 8'd0, 32'd5, 1'b0);
        send_item(KIND_REG, 8'd9, 32'd0, 1'b1);
        send_item(KIND_UNREG, 8'd0, 32'd0, 1'b0);
        send_item(KIND_TICK, 8'd0, 32'd0, 1'b0);
        send_item(KIND_UNREG, 8'd77, 32'd0, 1'b0);
    endtask

    // fill the table, overflow it, then expire a chain of one-shot slots
    task automatic test_full_table();
        send_item(KIND_REG, 8'hFF, 32'hFFFF_FFFF, 1'b0);
        for (int s = 1; s < SLOTS; s++) begin
            // duplicate tags, one periodic slot among one-shots
            send_item(KIND_REG, TAG_W'((s % 5) + 1), 32'd1, (s != 7));
        end
        send_item(KIND_REG, 8'd200, 32'd3, 1'b0);
        send_item(KIND_TICK, 8'd0, 32'd0, 1'b0);
        send_item(KIND_TICK, 8'hFF, 32'hFFFF_FFFF, 1'b1);
        send_item(KIND_UNREG, 8'd3, 32'd0, 1'b0);
        wait_for_results();
    endtask

    task automatic test_random_mix(input int send_pct, input int stall_pct, input int count);
        int               burst_left;
        int               roll;
        logic [TAG_W-1:0] tag;
        logic [31:0]      period;
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        burst_left     = 0;
        for (int k = 0; k < count; k++) begin
            // occasional register bursts push the table to full
            roll = $urandom_range(99);
            if (burst_left == 0 && roll < 3) burst_left = $urandom_range(20, 8);
            if (burst_left > 0) begin
                burst_left--;
                roll = 0;
            end else begin
                roll = $urandom_range(99);
            end

            if (roll < 35) begin
                tag  = ($urandom_range(99) < 60) ? TAG_W'($urandom_range(8, 1)) :
                                                   TAG_W'($urandom_range(255, 1));
                roll = $urandom_range(99);
                if (roll < 70)      period = $urandom_range(4, 1);
                else if (roll < 90) period = $urandom_range(40, 5);
                else                period = $urandom;
                send_item(KIND_REG, tag, period, 1'($urandom_range(1, 0)));
            end else if (roll < 50) begin
                // mostly tags that are in the table
                if (tbl_used > 0 && $urandom_range(99) < 70)
                    tag = tbl[$urandom_range(tbl_used - 1, 0)].tag;
                else
                    tag = TAG_W'($urandom_range(255, 1));
                send_item(KIND_UNREG, tag, $urandom, 1'($urandom_range(1, 0)));
            end else if (roll < 95) begin
                send_item(KIND_TICK, TAG_W'($urandom), $urandom, 1'($urandom_range(1, 0)));
            end else begin
                // malformed commands
                case ($urandom_range(3, 0))
                    0:       send_item(KIND_REG, 8'd0, $urandom, 1'($urandom_range(1, 0)));
                    1:       send_item(KIND_REG, TAG_W'($urandom_range(255, 1)), 32'd0,
                                       1'($urandom_range(1, 0)));
                    2:       send_item(KIND_UNREG, 8'd0, $urandom, 1'($urandom_range(1, 0)));
                    default: send_item(KIND_UNDEF, TAG_W'($urandom), $urandom,
                                       1'($urandom_range(1, 0)));
                endcase
            end

            if ($urandom_range(99) < 2) wait_for_results();
        end
        wait_for_results();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        cmd_ch.valid   <= 1'b0;
        cmd_ch.kind    <= KIND_TICK;
        cmd_ch.tag     <= '0;
        cmd_ch.period  <= '0;
        cmd_ch.mode    <= 1'b0;
        i_rst_n        <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        tbl_used       = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_rejects();
        test_full_table();
        test_random_mix(0, 0, 90);
        test_random_mix(88, 0, 80);
        test_random_mix(0, 88, 90);
        test_random_mix(10, 10, 95);

        wait_for_results();

        $display("summary: %0d commands, %0d result beats checked, %0d expirations,",
                 n_items, n_beats, n_fired);
        $display("summary: %0d full-table rejections, %0d mismatches, %0d beats missing",
                 n_full, n_errors, due_beats.size());
        if (n_errors == 0 && due_beats.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/tmr_pkg.sv
rtl/tmr_if.sv
rtl/tmr_ram.sv
rtl/tmr_ctrl.sv
rtl/tmr_dp.sv
rtl/multi_slot_software_timer_table_top.sv
test/testbench.sv
